### sv/dbbrs_pkg.sv
// shared constants, types and helper functions of the blink rate selector
package dbbrs_pkg;

  localparam int unsigned TIMER_WIDTH   = 16;
  localparam int unsigned COUNT_W       = 16;
  localparam int unsigned PERIOD_W      = 17;
  localparam int unsigned TICKS_W       = 16;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned ELAPSED_W     =
    (PERIOD_W > TIMER_WIDTH) ? PERIOD_W + 1 : TIMER_WIDTH + 2;

  localparam logic [PERIOD_W-1:0] RST_TIMER_PERIOD   = PERIOD_W'(42000);
  localparam logic [TICKS_W-1:0]  RST_SETTLE_TICKS   = TICKS_W'(2100);
  localparam logic [TICKS_W-1:0]  RST_INTERVAL_SLOW  = TICKS_W'(41999);
  localparam logic [TICKS_W-1:0]  RST_INTERVAL_MID   = TICKS_W'(21000);
  localparam logic [TICKS_W-1:0]  RST_INTERVAL_FAST  = TICKS_W'(10500);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMER_PERIOD   = 3'd0,
    CFG_SETTLE_TICKS   = 3'd1,
    CFG_INTERVAL_SLOW  = 3'd2,
    CFG_INTERVAL_MID   = 3'd3,
    CFG_INTERVAL_FAST  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RATE_SLOW = 2'd0,
    RATE_MID  = 2'd1,
    RATE_FAST = 2'd2
  } rate_e;

  typedef struct packed {
    logic [PERIOD_W-1:0] timer_period;
    logic [TICKS_W-1:0]  settle_ticks;
    logic [TICKS_W-1:0]  interval_slow;
    logic [TICKS_W-1:0]  interval_mid;
    logic [TICKS_W-1:0]  interval_fast;
  } cfg_t;

  typedef struct packed {
    logic       led_on;
    logic [1:0] rate_index;
    logic       rate_changed;
  } res_t;

  function automatic rate_e next_rate(rate_e cur);
    rate_e nxt;
    case (cur)
      RATE_SLOW: nxt = RATE_MID;
      RATE_MID:  nxt = RATE_FAST;
      default:   nxt = RATE_SLOW;
    endcase
    return nxt;
  endfunction

  // elapsed ticks modulo the timer period, zero period meaning full timer range
  function automatic logic [ELAPSED_W-1:0] elapsed_since(
    logic [TIMER_WIDTH-1:0] now_v,
    logic [TIMER_WIDTH-1:0] then_v,
    logic [PERIOD_W-1:0]    period
  );
    logic [ELAPSED_W-1:0] per;
    logic [ELAPSED_W-1:0] sum;
    logic [ELAPSED_W-1:0] res;
    per = (period == '0) ? (ELAPSED_W'(1) << TIMER_WIDTH) : ELAPSED_W'(period);
    sum = per + ELAPSED_W'(now_v);
    if (now_v >= then_v) begin
      res = ELAPSED_W'(now_v) - ELAPSED_W'(then_v);
    end else if (sum >= ELAPSED_W'(then_v)) begin
      res = sum - ELAPSED_W'(then_v);
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

### sv/dbbrs_sample_if.sv
// poll sample channel
interface dbbrs_sample_if;
  import dbbrs_pkg::*;

  logic               valid;
  logic               ready;
  logic               button_level;
  logic [COUNT_W-1:0] timer_count;

  modport source (output valid, output button_level, output timer_count, input ready);
  modport sink   (input valid, input button_level, input timer_count, output ready);
endinterface

### sv/dbbrs_result_if.sv
// result channel
interface dbbrs_result_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic [1:0] rate_index;
  logic       rate_changed;

  modport source (output valid, output led_on, output rate_index, output rate_changed,
                  input ready);
  modport sink   (input valid, input led_on, input rate_index, input rate_changed,
                  output ready);
endinterface

### sv/dbbrs_cfg_regs.sv
// configuration register file
module dbbrs_cfg_regs
  import dbbrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TIMER_PERIOD:   cfg_d.timer_period   = PERIOD_W'(cfg_data_i);
        CFG_SETTLE_TICKS:   cfg_d.settle_ticks   = TICKS_W'(cfg_data_i);
        CFG_INTERVAL_SLOW:  cfg_d.interval_slow  = TICKS_W'(cfg_data_i);
        CFG_INTERVAL_MID:   cfg_d.interval_mid   = TICKS_W'(cfg_data_i);
        CFG_INTERVAL_FAST:  cfg_d.interval_fast  = TICKS_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_period   <= RST_TIMER_PERIOD;
      cfg_q.settle_ticks   <= RST_SETTLE_TICKS;
      cfg_q.interval_slow  <= RST_INTERVAL_SLOW;
      cfg_q.interval_mid   <= RST_INTERVAL_MID;
      cfg_q.interval_fast  <= RST_INTERVAL_FAST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/dbbrs_core.sv
// debounce, rate select and blink state with the per-sample update logic
module dbbrs_core
  import dbbrs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   commit_i,
  input  logic                   button_i,
  input  logic [COUNT_W-1:0]     count_i,
  output res_t                   res_o
);

  logic                   last_raw_q, last_raw_d;
  logic [TIMER_WIDTH-1:0] raw_time_q, raw_time_d;
  logic                   stable_q, stable_d;
  rate_e                  rate_q, rate_d;
  logic [TIMER_WIDTH-1:0] toggle_time_q, toggle_time_d;
  logic                   led_q, led_d;

  logic [TIMER_WIDTH-1:0] now;
  logic                   raw_steady;
  logic                   accept_level;
  logic                   rise;
  logic [ELAPSED_W-1:0]   deb_elapsed;
  logic [ELAPSED_W-1:0]   blink_elapsed;
  logic [TICKS_W-1:0]     interval;
  logic                   toggle;

  assign now          = TIMER_WIDTH'(count_i);
  assign raw_steady   = (button_i == last_raw_q);
  assign deb_elapsed  = elapsed_since(now, raw_time_q, cfg_i.timer_period);
  // a fresh raw change is not yet steady, so it never passes the debounce
  assign accept_level = raw_steady && (button_i != stable_q) &&
                        (deb_elapsed > ELAPSED_W'(cfg_i.settle_ticks));
  assign rise         = accept_level && button_i;
  assign blink_elapsed = rise ? '0 : elapsed_since(now, toggle_time_q, cfg_i.timer_period);

  always_comb begin
    rate_d = rise ? next_rate(rate_q) : rate_q;
    case (rate_d)
      RATE_SLOW: interval = cfg_i.interval_slow;
      RATE_MID:  interval = cfg_i.interval_mid;
      default:   interval = cfg_i.interval_fast;
    endcase
  end

  assign toggle        = (blink_elapsed >= ELAPSED_W'(interval));
  assign last_raw_d    = button_i;
  assign raw_time_d    = raw_steady ? raw_time_q : now;
  assign stable_d      = accept_level ? button_i : stable_q;
  assign toggle_time_d = (rise || toggle) ? now : toggle_time_q;
  assign led_d         = toggle ? !led_q : led_q;

  assign res_o.led_on       = led_d;
  assign res_o.rate_index   = rate_d;
  assign res_o.rate_changed = rise;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q    <= 1'b0;
      raw_time_q    <= '0;
      stable_q      <= 1'b0;
      rate_q        <= RATE_SLOW;
      toggle_time_q <= '0;
      led_q         <= 1'b0;
    end else if (commit_i) begin
      last_raw_q    <= last_raw_d;
      raw_time_q    <= raw_time_d;
      stable_q      <= stable_d;
      rate_q        <= rate_d;
      toggle_time_q <= toggle_time_d;
      led_q         <= led_d;
    end
  end

endmodule

### sv/debounced_button_blink_rate_selector.sv
// top level of the debounced button blink rate selector
// Takes one poll sample (raw button level and timer count) per clock while the result side
// keeps taking and returns one result per sample: the LED level, the selected blink rate and
// a flag for a rate step. A sample is captured in an input register and then processed into
// an output register, from which its result is presented; the sustained rate is one sample
// per cycle while the result side keeps taking. The input register empties into the output
// register whenever that one is free or being taken, so a sample is still accepted while a
// finished result waits and the input register is empty. Configuration takes effect on the
// samples processed after the write; after reset the LED is off and the rate is slow.
module debounced_button_blink_rate_selector
  import dbbrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dbbrs_sample_if.sink          sample_i,
  dbbrs_result_if.source        result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t               cfg;
  res_t               res;
  logic               s1_valid_q;
  logic               s1_button_q;
  logic [COUNT_W-1:0] s1_count_q;
  logic               out_valid_q;
  res_t               out_res_q;
  logic               out_free;
  logic               s1_adv;
  logic               accept;

  assign out_free       = !out_valid_q || result_o.ready;
  assign s1_adv         = s1_valid_q && out_free;
  assign sample_i.ready = !s1_valid_q || out_free;
  assign accept         = sample_i.valid && sample_i.ready;

  dbbrs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dbbrs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .commit_i (s1_adv),
    .button_i (s1_button_q),
    .count_i  (s1_count_q),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_button_q <= sample_i.button_level;
      s1_count_q  <= sample_i.timer_count;
    end
    if (s1_adv) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.led_on       = out_res_q.led_on;
  assign result_o.rate_index   = out_res_q.rate_index;
  assign result_o.rate_changed = out_res_q.rate_changed;

endmodule

### sv/dbbrs_checker.sv
// port level assertions for the blink rate selector and their bind
module dbbrs_checker
  import dbbrs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       led_on_i,
  input logic [1:0] rate_index_i,
  input logic       rate_changed_i
);

  logic [1:0] pend_q;
  logic [1:0] last_rate_q;
  logic       in_acc;
  logic       out_acc;
  logic [1:0] next_idx;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign next_idx = (last_rate_q == RATE_MID) ? RATE_FAST :
                    (last_rate_q == RATE_SLOW) ? RATE_MID : RATE_SLOW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      last_rate_q <= RATE_SLOW;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
      if (out_acc) begin
        last_rate_q <= rate_index_i;
      end
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(led_on_i) && $stable(rate_index_i)
      && $stable(rate_changed_i))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without pending transaction");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && rate_changed_i |-> rate_index_i == next_idx)
    else $error("rate step out of order");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !rate_changed_i |-> rate_index_i == last_rate_q)
    else $error("rate moved without flag");

endmodule

bind debounced_button_blink_rate_selector dbbrs_checker u_dbbrs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .led_on_i       (result_o.led_on),
  .rate_index_i   (result_o.rate_index),
  .rate_changed_i (result_o.rate_changed)
);

### tb/tb_debounced_button_blink_rate_selector.sv
// self-checking testbench for the debounced button blink rate selector
module tb_debounced_button_blink_rate_selector;
  import dbbrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int          SCRIPT_LEN  = 31;

  typedef struct packed {
    bit                  load;
    cfg_idx_e            idx;
    logic [CFG_DATA_W-1:0] value;
    logic                btn;
    logic [COUNT_W-1:0]  cnt;
    bit                  typed;
    res_t                want;
  } row_t;

  // directed sequence, reset settings first, then a zero period with zero and extreme intervals
  localparam row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd0,     1'b1, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd41999, 1'b1, 4'b1000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd100,   1'b1, 4'b1000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd2201,  1'b1, 4'b1011},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd65535, 1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd0,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd3000,  1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd3000,  1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd3000,  1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd3001,  1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd5200,  1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd15700, 1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd20000, 1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd23000, 1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd23000, 1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd25101, 1'b0, 4'b0000},
    '{1'b1, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd0,     1'b0, 4'b0000},
    '{1'b1, CFG_SETTLE_TICKS,   17'd0,     1'b0, 16'd0,     1'b0, 4'b0000},
    '{1'b1, CFG_INTERVAL_SLOW,  17'd0,     1'b0, 16'd0,     1'b0, 4'b0000},
    '{1'b1, CFG_INTERVAL_MID,   17'd65535, 1'b0, 16'd0,     1'b0, 4'b0000},
    '{1'b1, CFG_INTERVAL_FAST,  17'd1,     1'b0, 16'd0,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd65535, 1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd0,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd1,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd0,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd5,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd6,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd7,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd8,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b1, 16'd9,     1'b0, 4'b0000},
    '{1'b0, CFG_TIMER_PERIOD,   17'd0,     1'b0, 16'd65534, 1'b0, 4'b0000}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dbbrs_sample_if smp ();
  dbbrs_result_if res ();

  debounced_button_blink_rate_selector dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .result_o   (res),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // blinker model state and settings
  logic [PERIOD_W-1:0] period_c;
  logic [TICKS_W-1:0]  debounce_c;
  logic [TICKS_W-1:0]  slow_c;
  logic [TICKS_W-1:0]  mid_c;
  logic [TICKS_W-1:0]  fast_c;
  logic                held_raw;
  logic [COUNT_W-1:0]  raw_stamp;
  logic                debounced;
  rate_e               rate_sel;
  logic [COUNT_W-1:0]  blink_stamp;
  logic                led;

  res_t        expected_blink_q [$];
  int unsigned errors;
  int unsigned cycles = 0;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_debounced_button_blink_rate_selector: errors");
    $finish;
  end

  always @(posedge clk_i) res.ready <= ($urandom_range(0, 99) >= rx_idle_pct);

  function automatic int unsigned ticks_between(int unsigned now_t, int unsigned then_t);
    int unsigned per;
    per = (period_c == '0) ? 32'd65536 : 32'(period_c);
    if (now_t >= then_t) return now_t - then_t;
    if (per + now_t >= then_t) return per + now_t - then_t;
    return 0;
  endfunction

  function automatic res_t step_blinker(logic btn, logic [COUNT_W-1:0] cnt);
    res_t        r;
    int unsigned iv;
    r.rate_changed = 1'b0;
    if (btn != held_raw) begin
      held_raw  = btn;
      raw_stamp = cnt;
    end
    if (ticks_between(32'(cnt), 32'(raw_stamp)) > debounce_c && btn != debounced) begin
      debounced = btn;
      if (btn) begin
        case (rate_sel)
          RATE_SLOW: rate_sel = RATE_MID;
          RATE_MID:  rate_sel = RATE_FAST;
          default:   rate_sel = RATE_SLOW;
        endcase
        blink_stamp    = cnt;
        r.rate_changed = 1'b1;
      end
    end
    case (rate_sel)
      RATE_SLOW: iv = 32'(slow_c);
      RATE_MID:  iv = 32'(mid_c);
      default:   iv = 32'(fast_c);
    endcase
    if (ticks_between(32'(cnt), 32'(blink_stamp)) >= iv) begin
      blink_stamp = cnt;
      led         = ~led;
    end
    r.led_on     = led;
    r.rate_index = rate_sel;
    return r;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      if (expected_blink_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction led_on %0b rate_index %0d rate_changed %0b",
                 $time, res.led_on, res.rate_index, res.rate_changed);
      end else begin
        want = expected_blink_q.pop_front();
        if (res.led_on !== want.led_on) begin
          errors++;
          $display("%0t: led_on expected %0b actual %0b", $time, want.led_on, res.led_on);
        end
        if (res.rate_index !== want.rate_index) begin
          errors++;
          $display("%0t: rate_index expected %0d actual %0d", $time, want.rate_index,
                   res.rate_index);
        end
        if (res.rate_changed !== want.rate_changed) begin
          errors++;
          $display("%0t: rate_changed expected %0b actual %0b", $time, want.rate_changed,
                   res.rate_changed);
        end
      end
    end
  end

  task automatic send_sample(logic btn, logic [COUNT_W-1:0] cnt, bit typed, res_t want);
    res_t got;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp.valid        <= 1'b1;
    smp.button_level <= btn;
    smp.timer_count  <= cnt;
    do @(posedge clk_i); while (smp.ready !== 1'b1);
    got = step_blinker(btn, cnt);
    expected_blink_q.push_back(typed ? want : got);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (expected_blink_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_TIMER_PERIOD:   period_c   = value;
      CFG_SETTLE_TICKS:   debounce_c = value[TICKS_W-1:0];
      CFG_INTERVAL_SLOW:  slow_c     = value[TICKS_W-1:0];
      CFG_INTERVAL_MID:   mid_c      = value[TICKS_W-1:0];
      CFG_INTERVAL_FAST:  fast_c     = value[TICKS_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] c_per;
    logic [CFG_DATA_W-1:0] c_deb;
    logic [CFG_DATA_W-1:0] c_slow;
    logic [CFG_DATA_W-1:0] c_mid;
    logic [CFG_DATA_W-1:0] c_fast;
    int unsigned           per_eff;
    int unsigned           step_max;
    int unsigned           tick;
    int unsigned           hold;
    logic                  level;
    logic                  btn;
    logic [COUNT_W-1:0]    cnt;

    errors      = 0;
    tx_idle_pct = 27;
    rx_idle_pct = 67;
    period_c    = RST_TIMER_PERIOD;
    debounce_c  = RST_SETTLE_TICKS;
    slow_c      = RST_INTERVAL_SLOW;
    mid_c       = RST_INTERVAL_MID;
    fast_c      = RST_INTERVAL_FAST;
    held_raw    = 1'b0;
    raw_stamp   = '0;
    debounced   = 1'b0;
    rate_sel    = RATE_SLOW;
    blink_stamp = '0;
    led         = 1'b0;

    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_TIMER_PERIOD;
    cfg_data_i       <= '0;
    smp.valid        <= 1'b0;
    smp.button_level <= 1'b0;
    smp.timer_count  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      if (SCRIPT[k].load) begin
        if (!SCRIPT[k-1].load) drain();
        write_reg(SCRIPT[k].idx, SCRIPT[k].value);
      end else begin
        cfg_we_i <= 1'b0;
        send_sample(SCRIPT[k].btn, SCRIPT[k].cnt, SCRIPT[k].typed, SCRIPT[k].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct = 27;
        rx_idle_pct = 67;
      end else if (p < 6) begin
        tx_idle_pct = 67;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (p)
        0: begin
          c_per = 17'd65536; c_deb = 17'd100; c_slow = 17'd500; c_mid = 17'd250;
          c_fast = 17'd50;
        end
        1: begin
          c_per = 17'd1; c_deb = 17'd0; c_slow = 17'd0; c_mid = 17'd1; c_fast = 17'd65535;
        end
        2: begin
          c_per = 17'd1000; c_deb = 17'd50; c_slow = 17'd250; c_mid = 17'd500;
          c_fast = 17'd1000;
        end
        3: begin
          c_per = 17'd0; c_deb = 17'd65535; c_slow = 17'd65535; c_mid = 17'd0;
          c_fast = 17'd32768;
        end
        default: begin
          c_per  = 17'($urandom_range(2, 65536));
          c_deb  = 17'($urandom_range(0, c_per / 8));
          c_slow = 17'($urandom_range(0, c_per - 1));
          c_mid  = 17'($urandom_range(0, c_per - 1));
          c_fast = 17'($urandom_range(0, c_per - 1));
        end
      endcase
      drain();
      write_reg(CFG_TIMER_PERIOD, c_per);
      write_reg(CFG_SETTLE_TICKS, c_deb);
      write_reg(CFG_INTERVAL_SLOW, c_slow);
      write_reg(CFG_INTERVAL_MID, c_mid);
      write_reg(CFG_INTERVAL_FAST, c_fast);
      cfg_we_i <= 1'b0;

      per_eff  = (c_per == '0) ? 65536 : 32'(c_per);
      step_max = 32'(c_deb / 2) + 1;
      tick     = 0;
      hold     = 0;
      level    = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          // noise: any level and any count, which may lie beyond the period
          btn = 1'($urandom_range(0, 1));
          cnt = 16'($urandom_range(0, 65535));
        end else begin
          if (hold == 0) begin
            level = ~level;
            hold  = $urandom_range(1, 12);
          end
          hold--;
          btn  = ($urandom_range(0, 99) < 15) ? ~level : level;
          tick = (tick + $urandom_range(0, step_max)) % per_eff;
          cnt  = 16'(tick);
        end
        send_sample(btn, cnt, 1'b0, '0);
      end
    end

    smp.valid <= 1'b0;
    while (expected_blink_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_debounced_button_blink_rate_selector: clean");
    end else begin
      $display("tb_debounced_button_blink_rate_selector: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/dbbrs_pkg.sv
sv/dbbrs_sample_if.sv
sv/dbbrs_result_if.sv
sv/dbbrs_cfg_regs.sv
sv/dbbrs_core.sv
sv/debounced_button_blink_rate_selector.sv
sv/dbbrs_checker.sv
tb/tb_debounced_button_blink_rate_selector.sv
